### src/kcm_pkg.sv
// kcm_pkg: shared types, constants and key maps for the key event translator
// no dependencies; used by kcm_xlate and keycode_to_char_with_modifiers
`default_nettype none

package kcm_pkg;

    localparam int KEY_ROWS  = 4;
    localparam int KEY_COLS  = 10;
    localparam int KEY_COUNT = KEY_ROWS * KEY_COLS;
    localparam int MAP_ROWS  = 4;
    localparam int MAP_COLS  = 10;

    localparam logic [7:0] IDX_SYMBOL    = 8'h1E;
    localparam logic [7:0] IDX_BACKSPACE = 8'h1D;
    localparam logic [7:0] IDX_B         = 8'h19;
    localparam logic [7:0] RAW_CAPS      = 8'h1D;
    localparam logic [7:0] RAW_FUNC      = 8'h15;
    localparam logic [7:0] CHAR_NULL     = 8'h00;
    localparam logic [7:0] CHAR_BS       = 8'h08;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

    localparam logic [7:0] CAPS_APP_RESET = 8'd240;
    localparam logic [7:0] FN_APP_RESET   = 8'd241;
    localparam logic [7:0] BL_LEVEL_RESET = 8'd127;

    typedef enum logic [1:0] {
        CFG_CAPS_APP = 2'd0,
        CFG_FN_APP   = 2'd1,
        CFG_BL_LEVEL = 2'd2
    } cfg_index_t;

    localparam logic [7:0] NORMAL_MAP [MAP_ROWS][MAP_COLS] = '{
        '{"q", "w", "e", "r", "t", "y", "u", "i", "o", "p"},
        '{"a", "s", "d", "f", "g", "h", "j", "k", "l", 8'h0A},
        '{8'h00, "z", "x", "c", "v", "b", "n", "m", 8'h00, 8'h00},
        '{8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [7:0] ALT_LAYER_MAP [MAP_ROWS][MAP_COLS] = '{
        '{"1", "2", "3", "4", "5", "6", "7", "8", "9", "0"},
        '{"*", "/", "+", "-", "=", ":", 8'h27, 8'h22, "@", 8'h00},
        '{8'h00, "_", "$", ";", "?", "!", ",", ".", 8'h00, 8'h00},
        '{8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    typedef struct packed {
        logic       key_pressed;
        logic [7:0] raw_code;
        logic       text_focus;
    } kcm_in_t;

    typedef struct packed {
        logic [7:0] key_code;
        logic       key_down;
        logic       notify;
        logic       haptic;
        logic [7:0] backlight_level;
    } kcm_out_t;

    typedef struct packed {
        logic [7:0] caps_app_code;
        logic [7:0] fn_app_code;
        logic [7:0] backlight_on_level;
    } kcm_cfg_t;

    typedef struct packed {
        logic       symbol_latch;
        logic       caps_latch;
        logic       function_latch;
        logic       backlight_guard;
        logic [7:0] previous_char;
        logic [7:0] held_key;
        logic       held_down;
        logic       app_key_active;
        logic [7:0] backlight_now;
    } kcm_state_t;

    // key index to character, null outside the maps
    function automatic logic [7:0] key_char(input logic sym, input logic [7:0] idx);
        logic [7:0] ch;
        ch = CHAR_NULL;
        for (int r = 0; r < KEY_ROWS && r < MAP_ROWS; r++) begin
            for (int c = 0; c < KEY_COLS && c < MAP_COLS; c++) begin
                if (idx == 8'(r * KEY_COLS + c)) begin
                    ch = sym ? ALT_LAYER_MAP[r][c] : NORMAL_MAP[r][c];
                end
            end
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

### src/kcm_xlate.sv
// kcm_xlate: combinational translation of one key event against the current state
// depends on kcm_pkg
`default_nettype none

module kcm_xlate (
    input  wire kcm_pkg::kcm_state_t st,
    input  wire kcm_pkg::kcm_cfg_t   cfg,
    input  wire kcm_pkg::kcm_in_t    ev,
    output kcm_pkg::kcm_state_t      st_next,
    output kcm_pkg::kcm_out_t        res
);

    typedef enum logic [1:0] {
        TR_NONE,
        TR_PRESSED,
        TR_RELEASED
    } tr_t;

    logic [7:0] idx;
    logic       key_valid;
    logic       app_press;
    logic       do_xlate;

    assign idx       = ev.raw_code - 8'd1;
    assign key_valid = (ev.raw_code != 8'd0) && (ev.raw_code <= 8'(kcm_pkg::KEY_COUNT));
    assign app_press = ev.key_pressed && !ev.text_focus &&
                       (ev.raw_code == kcm_pkg::RAW_CAPS || ev.raw_code == kcm_pkg::RAW_FUNC);
    assign do_xlate  = ev.key_pressed ? !app_press : !st.app_key_active;

    always_comb begin
        kcm_pkg::kcm_state_t nx;
        tr_t        tr;
        logic [7:0] key;
        logic [7:0] ch;
        logic       done;
        logic       prs;
        logic       notify;
        logic       haptic;

        nx     = st;
        tr     = TR_NONE;
        key    = kcm_pkg::CHAR_NULL;
        ch     = kcm_pkg::CHAR_NULL;
        done   = 1'b0;
        prs    = ev.key_pressed;
        notify = 1'b0;
        haptic = 1'b0;

        if (do_xlate && key_valid) begin
            if (idx == kcm_pkg::IDX_SYMBOL) begin
                nx.symbol_latch = !st.symbol_latch;
            end else if (ev.raw_code == kcm_pkg::RAW_CAPS) begin
                nx.caps_latch = !st.caps_latch;
                done = 1'b1;
            end else if (ev.raw_code == kcm_pkg::RAW_FUNC) begin
                nx.function_latch = !st.function_latch;
                done = 1'b1;
            end else if (idx == kcm_pkg::IDX_BACKSPACE) begin
                done = 1'b1;
                if (ev.key_pressed) begin
                    key              = kcm_pkg::CHAR_BS;
                    nx.previous_char = kcm_pkg::CHAR_BS;
                    tr               = TR_PRESSED;
                end
            end

            if (!done) begin
                if (ev.key_pressed && st.function_latch && idx == kcm_pkg::IDX_B) begin
                    nx.backlight_now   = (st.backlight_now != 8'd0) ? 8'd0
                                                                    : cfg.backlight_on_level;
                    nx.backlight_guard = 1'b1;
                    done = 1'b1;
                end else if (!ev.key_pressed && st.backlight_guard) begin
                    nx.backlight_guard = 1'b0;
                    done = 1'b1;
                end
            end

            if (!done) begin
                ch = kcm_pkg::key_char(nx.symbol_latch, idx);
                if (!nx.symbol_latch && st.caps_latch &&
                    ch >= kcm_pkg::CHAR_LOWER_A && ch <= kcm_pkg::CHAR_LOWER_Z) begin
                    ch = ch - kcm_pkg::CASE_OFFSET;
                end
                if (nx.symbol_latch && ch == kcm_pkg::CHAR_SPACE) begin
                    ch = kcm_pkg::CHAR_NULL;
                end else if (!nx.symbol_latch && st.previous_char == kcm_pkg::CHAR_NULL) begin
                    ch  = kcm_pkg::CHAR_SPACE;
                    prs = 1'b1;
                end
                nx.previous_char = ch;
                key = ch;
                tr  = prs ? TR_PRESSED : TR_RELEASED;
            end
        end

        if (!ev.key_pressed) begin
            nx.app_key_active = 1'b0;
            nx.held_down      = 1'b0;
            notify            = 1'b1;
        end else if (app_press) begin
            nx.app_key_active = 1'b1;
            nx.held_key       = (ev.raw_code == kcm_pkg::RAW_CAPS) ? cfg.caps_app_code
                                                                   : cfg.fn_app_code;
            nx.held_down      = 1'b1;
            notify            = 1'b1;
            haptic            = 1'b1;
        end else begin
            nx.app_key_active = 1'b0;
            if (tr == TR_PRESSED) begin
                nx.held_key  = key;
                nx.held_down = 1'b1;
                notify       = 1'b1;
                haptic       = 1'b1;
            end
        end

        st_next             = nx;
        res.key_code        = nx.held_key;
        res.key_down        = nx.held_down;
        res.notify          = notify;
        res.haptic          = haptic;
        res.backlight_level = nx.backlight_now;
    end

endmodule

`default_nettype wire

### src/keycode_to_char_with_modifiers.sv
// keycode_to_char_with_modifiers: top level with state, config registers and result register
// depends on kcm_pkg and kcm_xlate
`default_nettype none

// One key event beat gives exactly one result beat. Each event is translated by the
// combinational translator between the input port and the result register, so a new
// event is taken every cycle while the result register is empty or being read, and its
// result is valid in the cycle after it is taken. The configuration port is always ready;
// write it only while no event is in flight.
module keycode_to_char_with_modifiers (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire kcm_pkg::kcm_in_t  s_data,
    output logic                   m_valid,
    input  wire                    m_ready,
    output kcm_pkg::kcm_out_t      m_data,
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire [1:0]              cfg_index,
    input  wire [7:0]              cfg_data
);

    kcm_pkg::kcm_state_t state_reg;
    kcm_pkg::kcm_state_t state_next;
    kcm_pkg::kcm_cfg_t   cfg_reg;
    kcm_pkg::kcm_out_t   out_reg;
    kcm_pkg::kcm_out_t   out_next;
    logic                m_valid_reg;
    logic                in_beat;

    assign s_ready   = !m_valid_reg || m_ready;
    assign in_beat   = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    kcm_xlate u_xlate (
        .st      (state_reg),
        .cfg     (cfg_reg),
        .ev      (s_data),
        .st_next (state_next),
        .res     (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
            cfg_reg.caps_app_code      <= kcm_pkg::CAPS_APP_RESET;
            cfg_reg.fn_app_code        <= kcm_pkg::FN_APP_RESET;
            cfg_reg.backlight_on_level <= kcm_pkg::BL_LEVEL_RESET;
        end else begin
            if (in_beat) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    kcm_pkg::CFG_CAPS_APP: cfg_reg.caps_app_code      <= cfg_data;
                    kcm_pkg::CFG_FN_APP:   cfg_reg.fn_app_code        <= cfg_data;
                    kcm_pkg::CFG_BL_LEVEL: cfg_reg.backlight_on_level <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTH
    a_beat_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> m_valid)
        else $error("accepted beat did not produce a result");

    a_release_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && !s_data.key_pressed) |=>
            (!m_data.key_down && m_data.notify && !m_data.haptic))
        else $error("release beat reported wrongly");

    a_haptic_implies_press: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.haptic) |-> (m_data.key_down && m_data.notify))
        else $error("haptic without a reported press");

    a_state_holds_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_beat |=> $stable(state_reg))
        else $error("state changed without an input beat");
`endif

endmodule

`default_nettype wire
